// ===== rtl/core/kwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared types and constants of the k-way sorted merge engine.
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int unsigned NumListsDef  = 4;
  localparam int unsigned ListDepthDef = 128;
  localparam int unsigned DataW        = 32;
  localparam int unsigned IdW          = 2;
  localparam int unsigned StatusW      = 2;

  // Request codes of the req_type field.
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_MERGED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take in the input item
    logic append;   // finish an append and load the result
    logic scan;     // read the head of the current scan list
    logic take;     // finish a take and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_take;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/kwsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwsm_ctrl
// Sequencer of the merge engine: accepts one request at a time and steps the
// datapath through an append or a head scan.
// ----------------------------------------------------------------------------
module kwsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kwsm_pkg::sts_t sts_i,
  output kwsm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        // The request kind is known in the cycle after the transfer.
        if (sts_i.req_take) begin
          state_d = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.append = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.take = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Only one command of any kind, capture included, is issued in a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.capture, cmd_o.append, cmd_o.scan, cmd_o.take}) <= 1)
    else $error("kwsm_ctrl: more than one command at once");

  // A scan always runs into the drain cycle once the last list is read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan && sts_i.scan_last) |=> (state_q == S_DRAIN))
    else $error("kwsm_ctrl: scan did not end in drain");

  // A result is only produced when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.append || cmd_o.take) |-> sts_i.out_free)
    else $error("kwsm_ctrl: result issued while output register busy");

endmodule

// ===== rtl/core/kwsm_dp.sv =====
// ----------------------------------------------------------------------------
// kwsm_dp
// Datapath of the merge engine: list storage, per-list head pointers and fill
// counts, the head scan with its running minimum, and the output register.
// ----------------------------------------------------------------------------
module kwsm_dp #(
  parameter int unsigned NUM_LISTS  = kwsm_pkg::NumListsDef,
  parameter int unsigned LIST_DEPTH = kwsm_pkg::ListDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kwsm_pkg::cmd_t                      cmd_i,
  output kwsm_pkg::sts_t                      sts_o,
  input  logic                                req_type_i,
  input  logic [kwsm_pkg::IdW-1:0]            list_id_i,
  input  logic signed [kwsm_pkg::DataW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kwsm_pkg::StatusW-1:0]        status_o,
  output logic signed [kwsm_pkg::DataW-1:0]   merged_value_o,
  output logic [kwsm_pkg::IdW-1:0]            source_list_o
);

  localparam int unsigned IdxW  = $clog2(NUM_LISTS);
  localparam int unsigned PtrW  = $clog2(LIST_DEPTH);
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SumW  = PtrW + 1;
  localparam int unsigned AddrW = $clog2(NUM_LISTS * LIST_DEPTH);
  localparam int unsigned Words = NUM_LISTS * LIST_DEPTH;

  // Captured request.
  logic                             req_q;
  logic [kwsm_pkg::IdW-1:0]         id_q;
  logic signed [kwsm_pkg::DataW-1:0] value_q;

  // Per-list control state.
  logic [PtrW-1:0] head_q [NUM_LISTS];
  logic [CntW-1:0] fill_q [NUM_LISTS];

  // Scan state.
  logic [IdxW-1:0]                  scan_q;
  logic                             pipe_vld_q;
  logic [IdxW-1:0]                  pipe_idx_q;
  logic                             found_q;
  logic [IdxW-1:0]                  best_q;
  logic signed [kwsm_pkg::DataW-1:0] best_val_q;

  logic signed [kwsm_pkg::DataW-1:0] mem [Words];
  logic signed [kwsm_pkg::DataW-1:0] rd_q;

  // Output register.
  logic                              out_valid_q;
  kwsm_pkg::status_e                 status_q;
  logic signed [kwsm_pkg::DataW-1:0] merged_q;
  logic [kwsm_pkg::IdW-1:0]          source_q;

  logic [IdxW-1:0]  sel_idx;
  logic [PtrW-1:0]  sel_head;
  logic [CntW-1:0]  sel_fill;
  logic [SumW-1:0]  tail_sum;
  logic [PtrW-1:0]  tail_pos;
  logic [SumW-1:0]  head_inc;
  logic [PtrW-1:0]  head_next;
  logic [PtrW-1:0]  offset;
  logic [AddrW-1:0] addr;
  logic             id_ok;
  logic             can_append;
  logic             do_write;
  logic             out_free;

  // One index selects the per-list registers for every phase.
  always_comb begin
    if (cmd_i.scan) begin
      sel_idx = scan_q;
    end else if (cmd_i.take) begin
      sel_idx = best_q;
    end else begin
      sel_idx = IdxW'(id_q);
    end
  end

  assign sel_head = head_q[sel_idx];
  assign sel_fill = fill_q[sel_idx];

  // Tail position wraps inside the list's segment; the sum stays below twice
  // the depth, so a single subtraction is enough.
  assign tail_sum = SumW'(sel_head) + SumW'(sel_fill);
  assign tail_pos = (tail_sum >= SumW'(LIST_DEPTH)) ?
                    PtrW'(tail_sum - SumW'(LIST_DEPTH)) : PtrW'(tail_sum);
  assign head_inc  = SumW'(sel_head) + SumW'(1);
  assign head_next = (head_inc == SumW'(LIST_DEPTH)) ? '0 : PtrW'(head_inc);

  assign offset = cmd_i.scan ? sel_head : tail_pos;
  assign addr   = AddrW'(AddrW'(sel_idx) * AddrW'(LIST_DEPTH)) + AddrW'(offset);

  assign id_ok      = (32'(id_q) < NUM_LISTS);
  assign can_append = id_ok && (sel_fill != CntW'(LIST_DEPTH));
  assign do_write   = cmd_i.append && can_append;

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.req_take  = (req_q == kwsm_pkg::REQ_TAKE);
  assign sts_o.scan_last = (scan_q == IdxW'(NUM_LISTS - 1));
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= kwsm_pkg::REQ_APPEND;
      id_q    <= '0;
      value_q <= '0;
    end else if (cmd_i.capture) begin
      req_q   <= req_type_i;
      id_q    <= list_id_i;
      value_q <= value_i;
    end
  end

  // List storage: single port, one write or one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr] <= value_q;
    end
    if (cmd_i.scan) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_LISTS; n++) begin
        head_q[n] <= '0;
        fill_q[n] <= '0;
      end
    end else if (do_write) begin
      fill_q[sel_idx] <= sel_fill + CntW'(1);
    end else if (cmd_i.take && found_q) begin
      head_q[sel_idx] <= head_next;
      fill_q[sel_idx] <= sel_fill - CntW'(1);
    end
  end

  // Head scan: one list read per cycle, compared in the cycle after its read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      pipe_vld_q <= 1'b0;
      pipe_idx_q <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
    end else begin
      if (cmd_i.capture) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        scan_q <= scan_q + IdxW'(1);
      end
      pipe_vld_q <= cmd_i.scan && (sel_fill != '0);
      pipe_idx_q <= scan_q;
      // Strict compare keeps the lowest list index on ties.
      if (pipe_vld_q && (!found_q || (rd_q < best_val_q))) begin
        found_q <= 1'b1;
        best_q  <= pipe_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_vld_q && (!found_q || (rd_q < best_val_q))) begin
      best_val_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.append || cmd_i.take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      status_q <= can_append ? kwsm_pkg::ST_APPENDED : kwsm_pkg::ST_DROPPED;
      merged_q <= '0;
      source_q <= '0;
    end else if (cmd_i.take) begin
      if (found_q) begin
        status_q <= kwsm_pkg::ST_MERGED;
        merged_q <= best_val_q;
        source_q <= kwsm_pkg::IdW'(best_q);
      end else begin
        status_q <= kwsm_pkg::ST_EMPTY;
        merged_q <= '0;
        source_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign merged_value_o = merged_q;
  assign source_list_o  = source_q;

  // No list ever holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sel_fill) <= LIST_DEPTH)
    else $error("kwsm_dp: fill count beyond list depth");

  // A take that found a head reports a merged value on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && found_q) |=> (out_valid_q && status_q == kwsm_pkg::ST_MERGED))
    else $error("kwsm_dp: take with a head did not report a merged value");

  // A scan compare only ever considers a list that was non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && sel_fill == '0) |=> !pipe_vld_q)
    else $error("kwsm_dp: empty list entered the head compare");

endmodule

// ===== rtl/core/k_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merge engine over NUM_LISTS sorted lists held in FIFO segments of one
// list memory.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An append holds the input through the
// transfer cycle and a step that writes the list memory and loads the output
// register, which then offers the result. A take holds the input through the
// transfer cycle, a step that decodes the request, a scan in which the
// single-port list memory gives one head per cycle to a running minimum that
// compares each head in the cycle after its read, a step that compares the
// last head, and a step that advances the chosen list and loads the result
// into the output register. While an earlier result still waits, the final
// step of a request stretches until that result has been transferred. The
// output register lets the next request be taken while a result waits for
// its transfer. List storage needs no clearing after reset.
module k_way_sorted_merge #(
  parameter int unsigned NUM_LISTS  = kwsm_pkg::NumListsDef,
  parameter int unsigned LIST_DEPTH = kwsm_pkg::ListDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [kwsm_pkg::IdW-1:0]          list_id_i,
  input  logic signed [kwsm_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kwsm_pkg::StatusW-1:0]      status_o,
  output logic signed [kwsm_pkg::DataW-1:0] merged_value_o,
  output logic [kwsm_pkg::IdW-1:0]          source_list_o
);

  kwsm_pkg::cmd_t cmd;
  kwsm_pkg::sts_t sts;

  kwsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kwsm_dp #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .list_id_i      (list_id_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .merged_value_o (merged_value_o),
    .source_list_o  (source_list_o)
  );

endmodule
